// ===== hw/rtl/murmur64a_hash_top_defines.svh =====
// Assertion macros for the murmur64a_hash block.
`ifndef MURMUR64A_HASH_TOP_DEFINES_SVH
`define MURMUR64A_HASH_TOP_DEFINES_SVH
`ifndef SYNTH
`define MMH_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("mmh: property violated");
`define MMH_NEVER(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("mmh: forbidden condition seen");
`else
`define MMH_ASSERT(label, clk, rst_n, prop)
`define MMH_NEVER(label, clk, rst_n, expr)
`endif
`endif

// ===== hw/rtl/mmh_pkg.sv =====
// Shared types and constants for the murmur64a_hash block.
`timescale 1ns / 1ps
`default_nettype none
package mmh_pkg;

	localparam logic [63:0] MIX_MUL         = 64'hc6a4a7935bd1e995;
	localparam int          MIX_SHIFT       = 47;
	localparam int          WORD_W          = 64;
	localparam int          LEN_W           = 31;
	localparam int          SEED_W          = 32;
	localparam int          QUEUE_DEPTH_DEF = 4;

	typedef enum logic [1:0] {
		KIND_FULL,
		KIND_TAIL,
		KIND_EMPTY
	} kind_t;

	typedef struct packed {
		logic [WORD_W-1:0] word;
		logic [LEN_W-1:0]  len;
		kind_t             kind;
		logic              first;
		logic              last;
	} entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INIT,
		ST_BODY,
		ST_K1,
		ST_K2,
		ST_HM,
		ST_FIN,
		ST_OUT
	} core_state_t;

endpackage
`default_nettype wire

// ===== hw/rtl/mmh_front.sv =====
// Input stage: accepts items, classifies them and masks tail words.
`timescale 1ns / 1ps
`default_nettype none
module mmh_front import mmh_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    s_tvalid,
	output logic         s_tready,
	input  wire logic [95:0] s_tdata, // data_word[63:0], key_len[94:64], zero pad
	input  wire logic    s_tlast,   // last_word
	input  wire q_stat_t q_stat,
	output logic         push,
	output entry_t       push_ent
);

	logic              valid_s1;
	entry_t            ent_s1;
	logic              mid_q;
	logic              accept;
	logic [WORD_W-1:0] word;
	logic [LEN_W-1:0]  len;
	logic [WORD_W-1:0] mask;
	entry_t            ent_new;

	assign word = s_tdata[WORD_W-1:0];
	assign len  = s_tdata[WORD_W+LEN_W-1:WORD_W];

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			mask[i*8 +: 8] = (3'(i) < len[2:0]) ? 8'hff : 8'h00;
		end
	end

	always_comb begin
		ent_new.len   = len;
		ent_new.first = !mid_q;
		ent_new.last  = s_tlast;
		ent_new.word  = word;
		if (!s_tlast) begin
			ent_new.kind = KIND_FULL;
		end else if (len[2:0] != 3'd0) begin
			ent_new.kind = KIND_TAIL;
			ent_new.word = word & mask;
		end else if (len != '0) begin
			ent_new.kind = KIND_FULL;
		end else begin
			ent_new.kind = KIND_EMPTY;
		end
	end

	assign push     = valid_s1 && !q_stat.full;
	assign push_ent = ent_s1;
	assign s_tready = !valid_s1 || !q_stat.full;
	assign accept   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			mid_q    <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
			mid_q    <= !s_tlast;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ent_s1 <= ent_new;
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/mmh_queue.sv =====
// Small register queue between the input stage and the hash core.
`timescale 1ns / 1ps
`default_nettype none
module mmh_queue import mmh_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   push,
	input  wire entry_t push_ent,
	input  wire logic   pop,
	output entry_t      head,
	output q_stat_t     q_stat
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	entry_t            mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_push;
	logic              do_pop;

	assign q_stat.full  = (count_q == CNT_W'(DEPTH));
	assign q_stat.empty = (count_q == '0);
	assign do_push      = push && !q_stat.full;
	assign do_pop       = pop && !q_stat.empty;
	assign head         = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_ent;
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/mmh_core.sv =====
// Hash core: sequencer around one shared 32x32 multiplier, plus output register.
`timescale 1ns / 1ps
`default_nettype none
module mmh_core import mmh_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [SEED_W-1:0] seed,
	input  wire entry_t            head,
	input  wire q_stat_t           q_stat,
	output logic                   pop,
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output logic [63:0]            m_tdata  // hash_value
);

	function automatic logic [63:0] xshift(input logic [63:0] v);
		xshift = v ^ (v >> MIX_SHIFT);
	endfunction

	core_state_t state_q;
	core_state_t state_d;
	logic [1:0]  cnt_q;
	entry_t      ent_q;
	logic [63:0] h_q;
	logic [63:0] x_q;
	logic [63:0] acc_q;
	logic [63:0] res_q;
	logic        out_valid_q;
	logic [63:0] out_hash_q;
	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [63:0] prod;
	logic [63:0] mul_res;
	logic        is_mul;
	logic        mul_done;
	logic        out_load;

	// low 64 bits of x * MIX_MUL over three partial products
	always_comb begin
		case (cnt_q)
			2'd0: begin
				mul_a = x_q[31:0];
				mul_b = MIX_MUL[31:0];
			end
			2'd1: begin
				mul_a = x_q[63:32];
				mul_b = MIX_MUL[31:0];
			end
			default: begin
				mul_a = x_q[31:0];
				mul_b = MIX_MUL[63:32];
			end
		endcase
	end

	assign prod     = 64'(mul_a) * 64'(mul_b);
	assign mul_res  = {acc_q[63:32] + prod[31:0], acc_q[31:0]};
	assign is_mul   = (state_q == ST_INIT) || (state_q == ST_K1) || (state_q == ST_K2) ||
		(state_q == ST_HM) || (state_q == ST_FIN);
	assign mul_done = is_mul && (cnt_q == 2'd2);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (!q_stat.empty) begin
					state_d = head.first ? ST_INIT : ST_BODY;
				end
			end
			ST_INIT: begin
				if (mul_done) state_d = ST_BODY;
			end
			ST_BODY: begin
				case (ent_q.kind)
					KIND_FULL: state_d = ST_K1;
					KIND_TAIL: state_d = ST_HM;
					default:   state_d = ent_q.last ? ST_FIN : ST_IDLE;
				endcase
			end
			ST_K1: begin
				if (mul_done) state_d = ST_K2;
			end
			ST_K2: begin
				if (mul_done) state_d = ST_HM;
			end
			ST_HM: begin
				if (mul_done) state_d = ent_q.last ? ST_FIN : ST_IDLE;
			end
			ST_FIN: begin
				if (mul_done) state_d = ST_OUT;
			end
			ST_OUT: begin
				if (out_load) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		pop      = (state_q == ST_IDLE) && !q_stat.empty;
		out_load = (state_q == ST_OUT) && (!out_valid_q || m_tready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= (is_mul && !mul_done) ? cnt_q + 2'd1 : 2'd0;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (is_mul && cnt_q == 2'd0) begin
			acc_q <= prod;
		end else if (is_mul && cnt_q == 2'd1) begin
			acc_q[63:32] <= acc_q[63:32] + prod[31:0];
		end
		case (state_q)
			ST_IDLE: begin
				if (pop) begin
					ent_q <= head;
					x_q   <= {{(64-LEN_W){1'b0}}, head.len};
				end
			end
			ST_INIT: begin
				if (mul_done) h_q <= {{(64-SEED_W){1'b0}}, seed} ^ mul_res;
			end
			ST_BODY: begin
				case (ent_q.kind)
					KIND_FULL: x_q <= ent_q.word;
					KIND_TAIL: x_q <= h_q ^ ent_q.word;
					default:   x_q <= xshift(h_q);
				endcase
			end
			ST_K1: begin
				if (mul_done) x_q <= xshift(mul_res);
			end
			ST_K2: begin
				if (mul_done) x_q <= h_q ^ mul_res;
			end
			ST_HM: begin
				if (mul_done) begin
					h_q <= mul_res;
					x_q <= xshift(mul_res);
				end
			end
			ST_FIN: begin
				if (mul_done) res_q <= xshift(mul_res);
			end
			default: begin
			end
		endcase
		if (out_load) begin
			out_hash_q <= res_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_hash_q;

endmodule
`default_nettype wire

// ===== hw/rtl/murmur64a_hash_top.sv =====
// Top level of the streaming MurmurHash64A block.
// Usage:
//   Input stream s_*: one item per 8-byte key word, little-endian in s_tdata[63:0],
//   total key length in s_tdata[94:64] on every item, s_tlast on the final item.
//   A zero-length key is a single item whose data is ignored.
//   Output stream m_*: one item per key, the 64-bit hash in m_tdata.
//   cfg_wr_en/cfg_wr_data: seed write, only while the block is idle.
// Work per item: the core runs one shared 32x32 multiplier for each 64-bit
//   multiply. A full word takes two key multiplies and a hash multiply, a tail
//   word one hash multiply; the first item of a key adds the seed multiply and
//   the last adds the finalization multiply.
// The input stage and a short queue keep taking items while the core works
//   and while a finished hash waits on the output register.
// When m_tready is low the output holds; the core then stops only at its
//   next finished hash, and the queue fills before s_tready drops.
// Reset clears the seed, the key-in-progress flag, the queue and the core.
`timescale 1ns / 1ps
`default_nettype none
`include "murmur64a_hash_top_defines.svh"
module murmur64a_hash_top import mmh_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire logic [95:0]       s_tdata,   // data_word[63:0], key_len[94:64], zero pad
	input  wire logic              s_tlast,   // last_word
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output logic [63:0]            m_tdata,   // hash_value[63:0]
	input  wire logic              cfg_wr_en,
	input  wire logic [SEED_W-1:0] cfg_wr_data
);

	logic [SEED_W-1:0] seed_q;
	q_stat_t           q_stat;
	logic              push;
	entry_t            push_ent;
	logic              pop;
	entry_t            head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= '0;
		end else if (cfg_wr_en) begin
			seed_q <= cfg_wr_data;
		end
	end

	mmh_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.q_stat   (q_stat),
		.push     (push),
		.push_ent (push_ent)
	);

	mmh_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_ent (push_ent),
		.pop      (pop),
		.head     (head),
		.q_stat   (q_stat)
	);

	mmh_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.seed     (seed_q),
		.head     (head),
		.q_stat   (q_stat),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	`MMH_NEVER(a_no_overflow, clk, arst_n, push && q_stat.full)
	`MMH_NEVER(a_no_underflow, clk, arst_n, pop && q_stat.empty)
	`MMH_ASSERT(a_push_fills, clk, arst_n, (push && q_stat.empty) |=> !q_stat.empty)

endmodule
`default_nettype wire
